>>> rtl/core/plrt_pkg.sv
// Shared types and constants for the Plucker line rigid transform core.
`default_nettype none

package plrt_pkg;

    // Fixed-point fraction bits of the configured rotation and translation
    localparam int ROT_FRAC   = 14;
    localparam int TRANS_FRAC = 12;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_ROT_ROW0 = 2'd0,
        CFG_ROT_ROW1 = 2'd1,
        CFG_ROT_ROW2 = 2'd2,
        CFG_TRANS    = 2'd3
    } t_cfg_idx;

    // Stage enables for the matrix-vector unit
    typedef struct packed {
        logic en_prod;
        logic en_sum;
    } t_rot_ctl;

endpackage

`default_nettype wire

>>> rtl/core/plrt_rot3.sv
// Two-stage 3x3 rotation times vector: products, then row sums with rounding.
`default_nettype none

module plrt_rot3 #(
    parameter int ROT_WIDTH   = 16,
    parameter int COORD_WIDTH = 24
) (
    input  wire logic                                   i_clk,
    input  wire plrt_pkg::t_rot_ctl                     i_ctl,
    input  wire logic [3*ROT_WIDTH-1:0]                 i_row0,
    input  wire logic [3*ROT_WIDTH-1:0]                 i_row1,
    input  wire logic [3*ROT_WIDTH-1:0]                 i_row2,
    input  wire logic signed [COORD_WIDTH-1:0]          i_v0,
    input  wire logic signed [COORD_WIDTH-1:0]          i_v1,
    input  wire logic signed [COORD_WIDTH-1:0]          i_v2,
    output logic signed [ROT_WIDTH+COORD_WIDTH+1-plrt_pkg::ROT_FRAC:0] o_r0,
    output logic signed [ROT_WIDTH+COORD_WIDTH+1-plrt_pkg::ROT_FRAC:0] o_r1,
    output logic signed [ROT_WIDTH+COORD_WIDTH+1-plrt_pkg::ROT_FRAC:0] o_r2
);
    import plrt_pkg::*;

    localparam int PROD_W = ROT_WIDTH + COORD_WIDTH;
    localparam int ACC_W  = PROD_W + 2;
    localparam int RES_W  = ACC_W - ROT_FRAC;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1 << (ROT_FRAC - 1));

    logic [3*ROT_WIDTH-1:0]        w_rows [3];
    logic signed [COORD_WIDTH-1:0] w_vec  [3];
    logic signed [PROD_W-1:0]      r_prod [3][3];
    logic signed [ACC_W-1:0]       n_acc  [3];
    logic signed [RES_W-1:0]       r_res  [3];

    assign w_rows[0] = i_row0;
    assign w_rows[1] = i_row1;
    assign w_rows[2] = i_row2;
    assign w_vec[0]  = i_v0;
    assign w_vec[1]  = i_v1;
    assign w_vec[2]  = i_v2;

    // Stage 1: nine signed products
    always_ff @(posedge i_clk) begin
        if (i_ctl.en_prod) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_prod[r][c] <= $signed(w_rows[r][c*ROT_WIDTH +: ROT_WIDTH]) * w_vec[c];
                end
            end
        end
    end

    // Row sums plus half an LSB; floor shift gives round half up
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_acc[r] = ACC_W'(r_prod[r][0]) + ACC_W'(r_prod[r][1])
                     + ACC_W'(r_prod[r][2]) + HALF;
        end
    end

    // Stage 2: rounded result, kept at full width
    always_ff @(posedge i_clk) begin
        if (i_ctl.en_sum) begin
            for (int r = 0; r < 3; r++) begin
                r_res[r] <= n_acc[r][ACC_W-1:ROT_FRAC];
            end
        end
    end

    assign o_r0 = r_res[0];
    assign o_r1 = r_res[1];
    assign o_r2 = r_res[2];

endmodule

`default_nettype wire

>>> rtl/core/plucker_line_rigid_transform_core.sv
// Throughput: one line per cycle unless the output stalls; five register stages
// (products, row sums, cross products, moment sum, saturation) move under a ready
// chain. A stage holds while everything after it is full and the output is stalled.
// Reset (i_rst_n low, synchronous) empties all stages, loads the identity
// rotation and a zero translation.
`default_nettype none

module plucker_line_rigid_transform_core #(
    parameter int COORD_WIDTH = 24,
    parameter int ROT_WIDTH   = 16,
    parameter int TRANS_WIDTH = 20
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration write port
    input  wire logic                          i_cfg_we,
    input  wire plrt_pkg::t_cfg_idx            i_cfg_idx,
    input  wire logic [((ROT_WIDTH > TRANS_WIDTH) ? 3*ROT_WIDTH : 3*TRANS_WIDTH)-1:0]
                                               i_cfg_data,
    // input line
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic signed [COORD_WIDTH-1:0] i_normal_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_normal_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_normal_z,
    input  wire logic signed [COORD_WIDTH-1:0] i_dir_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_dir_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_dir_z,
    // transformed line
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic signed [COORD_WIDTH-1:0]      o_cam_normal_x,
    output logic signed [COORD_WIDTH-1:0]      o_cam_normal_y,
    output logic signed [COORD_WIDTH-1:0]      o_cam_normal_z,
    output logic signed [COORD_WIDTH-1:0]      o_cam_dir_x,
    output logic signed [COORD_WIDTH-1:0]      o_cam_dir_y,
    output logic signed [COORD_WIDTH-1:0]      o_cam_dir_z,
    output logic                               o_overflow
);
    import plrt_pkg::*;

    localparam int ROW_W   = 3 * ROT_WIDTH;
    localparam int TPK_W   = 3 * TRANS_WIDTH;
    localparam int RD_W    = ROT_WIDTH + COORD_WIDTH + 2 - ROT_FRAC;
    localparam int XP_W    = TRANS_WIDTH + RD_W;
    localparam int SUM_W   = XP_W + 2;
    localparam int NC_W    = SUM_W - TRANS_FRAC;
    localparam logic [ROW_W-1:0] ROW0_RST = ROW_W'(64'd1 << ROT_FRAC);
    localparam logic [ROW_W-1:0] ROW1_RST = ROW_W'(64'd1 << (ROT_FRAC + ROT_WIDTH));
    localparam logic [ROW_W-1:0] ROW2_RST = ROW_W'(64'd1 << (ROT_FRAC + 2*ROT_WIDTH));
    localparam logic signed [SUM_W-1:0] HALF_T = SUM_W'(1 << (TRANS_FRAC - 1));

    // Clamp to the coordinate range; MSB of the result is the saturation flag
    function automatic logic [COORD_WIDTH:0] sat_coord(input logic signed [NC_W-1:0] x);
        logic                   hi_ovf;
        logic                   lo_ovf;
        logic [COORD_WIDTH-1:0] v;
        hi_ovf = !x[NC_W-1] && (|x[NC_W-2:COORD_WIDTH-1]);
        lo_ovf = x[NC_W-1] && !(&x[NC_W-2:COORD_WIDTH-1]);
        if (hi_ovf) begin
            v = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end else if (lo_ovf) begin
            v = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end else begin
            v = x[COORD_WIDTH-1:0];
        end
        return {hi_ovf || lo_ovf, v};
    endfunction

    // Configuration registers
    logic [ROW_W-1:0] r_row0;
    logic [ROW_W-1:0] r_row1;
    logic [ROW_W-1:0] r_row2;
    logic [TPK_W-1:0] r_trans;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row0  <= ROW0_RST;
            r_row1  <= ROW1_RST;
            r_row2  <= ROW2_RST;
            r_trans <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROT_ROW0: r_row0  <= i_cfg_data[ROW_W-1:0];
                CFG_ROT_ROW1: r_row1  <= i_cfg_data[ROW_W-1:0];
                CFG_ROT_ROW2: r_row2  <= i_cfg_data[ROW_W-1:0];
                CFG_TRANS:    r_trans <= i_cfg_data[TPK_W-1:0];
            endcase
        end
    end

    // Pipeline valids and the ready chain (a stage moves when it is empty
    // or the stage after it moves)
    logic r_vld_a, r_vld_b, r_vld_c, r_vld_d, r_vld_e;
    logic w_en_a, w_en_b, w_en_c, w_en_d, w_en_e;
    t_rot_ctl w_rot_ctl;

    assign w_en_e     = !r_vld_e || i_out_ready;
    assign w_en_d     = !r_vld_d || w_en_e;
    assign w_en_c     = !r_vld_c || w_en_d;
    assign w_en_b     = !r_vld_b || w_en_c;
    assign w_en_a     = !r_vld_a || w_en_b;
    assign o_in_ready = w_en_a;
    assign w_rot_ctl  = '{en_prod: w_en_a, en_sum: w_en_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
            r_vld_d <= 1'b0;
            r_vld_e <= 1'b0;
        end else begin
            if (w_en_a) r_vld_a <= i_in_valid;
            if (w_en_b) r_vld_b <= r_vld_a;
            if (w_en_c) r_vld_c <= r_vld_b;
            if (w_en_d) r_vld_d <= r_vld_c;
            if (w_en_e) r_vld_e <= r_vld_d;
        end
    end

    // Stages A and B: R*n and R*d
    logic signed [RD_W-1:0] w_rn [3];
    logic signed [RD_W-1:0] w_rd [3];

    plrt_rot3 #(
        .ROT_WIDTH   (ROT_WIDTH),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_rot_n (
        .i_clk  (i_clk),
        .i_ctl  (w_rot_ctl),
        .i_row0 (r_row0),
        .i_row1 (r_row1),
        .i_row2 (r_row2),
        .i_v0   (i_normal_x),
        .i_v1   (i_normal_y),
        .i_v2   (i_normal_z),
        .o_r0   (w_rn[0]),
        .o_r1   (w_rn[1]),
        .o_r2   (w_rn[2])
    );

    plrt_rot3 #(
        .ROT_WIDTH   (ROT_WIDTH),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_rot_d (
        .i_clk  (i_clk),
        .i_ctl  (w_rot_ctl),
        .i_row0 (r_row0),
        .i_row1 (r_row1),
        .i_row2 (r_row2),
        .i_v0   (i_dir_x),
        .i_v1   (i_dir_y),
        .i_v2   (i_dir_z),
        .o_r0   (w_rd[0]),
        .o_r1   (w_rd[1]),
        .o_r2   (w_rd[2])
    );

    // Stage C: cross product terms t x (R*d); component i = pa[i] - pb[i]
    logic signed [TRANS_WIDTH-1:0] w_t [3];
    logic signed [XP_W-1:0]        r_pa [3];
    logic signed [XP_W-1:0]        r_pb [3];
    logic signed [RD_W-1:0]        r_rn_c [3];
    logic signed [RD_W-1:0]        r_rd_c [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_t[i] = $signed(r_trans[i*TRANS_WIDTH +: TRANS_WIDTH]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_c) begin
            r_pa[0] <= w_t[1] * w_rd[2];
            r_pb[0] <= w_t[2] * w_rd[1];
            r_pa[1] <= w_t[2] * w_rd[0];
            r_pb[1] <= w_t[0] * w_rd[2];
            r_pa[2] <= w_t[0] * w_rd[1];
            r_pb[2] <= w_t[1] * w_rd[0];
            for (int i = 0; i < 3; i++) begin
                r_rn_c[i] <= w_rn[i];
                r_rd_c[i] <= w_rd[i];
            end
        end
    end

    // Stage D: R*n aligned to 12 fraction bits plus the cross product, with bias
    logic signed [SUM_W-1:0] r_sum  [3];
    logic signed [RD_W-1:0]  r_rd_d [3];

    always_ff @(posedge i_clk) begin
        if (w_en_d) begin
            for (int i = 0; i < 3; i++) begin
                r_sum[i]  <= (SUM_W'(r_rn_c[i]) <<< TRANS_FRAC) + SUM_W'(r_pa[i])
                           - SUM_W'(r_pb[i]) + HALF_T;
                r_rd_d[i] <= r_rd_c[i];
            end
        end
    end

    // Stage E: round, saturate, merge the flags
    logic [COORD_WIDTH:0] w_sat_n [3];
    logic [COORD_WIDTH:0] w_sat_d [3];
    logic                 w_ovf;

    always_comb begin
        w_ovf = 1'b0;
        for (int i = 0; i < 3; i++) begin
            w_sat_n[i] = sat_coord(r_sum[i][SUM_W-1:TRANS_FRAC]);
            w_sat_d[i] = sat_coord(NC_W'(r_rd_d[i]));
            w_ovf      = w_ovf | w_sat_n[i][COORD_WIDTH] | w_sat_d[i][COORD_WIDTH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_e) begin
            o_cam_normal_x <= w_sat_n[0][COORD_WIDTH-1:0];
            o_cam_normal_y <= w_sat_n[1][COORD_WIDTH-1:0];
            o_cam_normal_z <= w_sat_n[2][COORD_WIDTH-1:0];
            o_cam_dir_x    <= w_sat_d[0][COORD_WIDTH-1:0];
            o_cam_dir_y    <= w_sat_d[1][COORD_WIDTH-1:0];
            o_cam_dir_z    <= w_sat_d[2][COORD_WIDTH-1:0];
            o_overflow     <= w_ovf;
        end
    end

    assign o_out_valid = r_vld_e;

endmodule

`default_nettype wire

>>> rtl/core/plrt_checker.sv
// Port-level checks for the Plucker line transform core, bound to the top level.
`default_nettype none

module plrt_checker #(
    parameter int COORD_WIDTH = 24
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          o_in_ready,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_ready,
    input wire logic signed [COORD_WIDTH-1:0] o_cam_normal_x,
    input wire logic signed [COORD_WIDTH-1:0] o_cam_normal_y,
    input wire logic signed [COORD_WIDTH-1:0] o_cam_normal_z,
    input wire logic signed [COORD_WIDTH-1:0] o_cam_dir_x,
    input wire logic signed [COORD_WIDTH-1:0] o_cam_dir_y,
    input wire logic signed [COORD_WIDTH-1:0] o_cam_dir_z,
    input wire logic                          o_overflow
);
    localparam logic [COORD_WIDTH-1:0] MAXV = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] MINV = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // Some component sits at a clamp limit
    logic w_at_limit;
    assign w_at_limit = (o_cam_normal_x == MAXV) || (o_cam_normal_x == MINV)
                     || (o_cam_normal_y == MAXV) || (o_cam_normal_y == MINV)
                     || (o_cam_normal_z == MAXV) || (o_cam_normal_z == MINV)
                     || (o_cam_dir_x == MAXV) || (o_cam_dir_x == MINV)
                     || (o_cam_dir_y == MAXV) || (o_cam_dir_y == MINV)
                     || (o_cam_dir_z == MAXV) || (o_cam_dir_z == MINV);

    // A stalled result keeps its valid, normal x, direction z and overflow flag
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_cam_normal_x)
            && $stable(o_cam_dir_z) && $stable(o_overflow))
        else $error("stalled result changed");

    // Reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // With nothing waiting at the output the core always takes input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with an empty output");

    // Saturation flag needs a clamped component
    a_ovf_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overflow |-> w_at_limit)
        else $error("overflow flagged without a clamped component");

    // An input transaction is refused only while a result waits at the output
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("core blocked input without a stalled result");

endmodule

bind plucker_line_rigid_transform_core plrt_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_plrt_checker (.*);

`default_nettype wire

>>> tb/plucker_line_rigid_transform_core_test.sv
// Self-checking testbench for the Plucker line rigid transform core.
`default_nettype none

module plucker_line_rigid_transform_core_test;
    import plrt_pkg::*;

    localparam int COORD_W   = 24;
    localparam int ROT_W     = 16;
    localparam int TRANS_W   = 20;
    localparam int CFG_W     = 60;
    localparam int LATENCY   = 5;
    localparam int LIMIT     = 200000;
    localparam int PHASES    = 7;
    localparam int PER_PHASE = 250;

    localparam logic [COORD_W-1:0] C_MAX = 24'h7FFFFF;
    localparam logic [COORD_W-1:0] C_MIN = 24'h800000;
    localparam logic [ROT_W-1:0]   R_ONE = 16'h4000;

    localparam t_cfg_idx ROW_REG [3] = '{CFG_ROT_ROW0, CFG_ROT_ROW1, CFG_ROT_ROW2};

    typedef struct packed {
        logic [COORD_W-1:0] nx, ny, nz, dx, dy, dz;
    } line_t;

    typedef struct packed {
        logic [COORD_W-1:0] nx, ny, nz, dx, dy, dz;
        logic               ovf;
    } cam_t;

    // one row of the directed plan: a register write or a line transaction
    typedef struct {
        bit          is_cfg;
        t_cfg_idx    idx;
        logic [CFG_W-1:0] data;
        line_t       ln;
        bit          typed;
        cam_t        want;
    } plan_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic             cfg_we;
    t_cfg_idx         cfg_idx;
    logic [CFG_W-1:0] cfg_data;

    logic  in_valid;
    logic  o_in_ready;
    line_t in_line;

    logic o_out_valid;
    logic out_ready = 1'b0;
    logic [COORD_W-1:0] o_cam_normal_x, o_cam_normal_y, o_cam_normal_z;
    logic [COORD_W-1:0] o_cam_dir_x, o_cam_dir_y, o_cam_dir_z;
    logic o_overflow;

    // mirror of the configuration registers
    logic [3*ROT_W-1:0]   rot_row [3];
    logic [3*TRANS_W-1:0] trans_xyz;

    cam_t      cam_lines_due [$];
    plan_row_t plan [$];
    int        bad_count    = 0;
    int        result_count = 0;
    int        cycles       = 0;
    bit        calm         = 1'b0;

    plucker_line_rigid_transform_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_normal_x     (in_line.nx),
        .i_normal_y     (in_line.ny),
        .i_normal_z     (in_line.nz),
        .i_dir_x        (in_line.dx),
        .i_dir_y        (in_line.dy),
        .i_dir_z        (in_line.dz),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_cam_normal_x (o_cam_normal_x),
        .o_cam_normal_y (o_cam_normal_y),
        .o_cam_normal_z (o_cam_normal_z),
        .o_cam_dir_x    (o_cam_dir_x),
        .o_cam_dir_y    (o_cam_dir_y),
        .o_cam_dir_z    (o_cam_dir_z),
        .o_overflow     (o_overflow)
    );

    // 20-unit clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // round to nearest, ties toward +inf
    function automatic longint round_half_up(longint x, int s);
        return (x + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp_coord(longint x);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (COORD_W - 1)) - 1;
        lo = -hi - 1;
        if (x > hi) return hi;
        if (x < lo) return lo;
        return x;
    endfunction

    // d' = R*d, n' = R*n + t x (R*d), using the mirrored registers
    function automatic cam_t to_camera_frame(line_t ln);
        longint n [3], d [3], rn [3], rd [3], t [3], cr [3], nc [3], dc [3];
        longint acc_n, acc_d, sum;
        bit     ovf;
        cam_t   res;
        ovf  = 1'b0;
        n[0] = $signed(ln.nx);
        n[1] = $signed(ln.ny);
        n[2] = $signed(ln.nz);
        d[0] = $signed(ln.dx);
        d[1] = $signed(ln.dy);
        d[2] = $signed(ln.dz);
        for (int i = 0; i < 3; i++)
            t[i] = $signed(trans_xyz[i*TRANS_W +: TRANS_W]);
        for (int r = 0; r < 3; r++) begin
            acc_n = 0;
            acc_d = 0;
            for (int c = 0; c < 3; c++) begin
                acc_n += longint'($signed(rot_row[r][c*ROT_W +: ROT_W])) * n[c];
                acc_d += longint'($signed(rot_row[r][c*ROT_W +: ROT_W])) * d[c];
            end
            rn[r] = round_half_up(acc_n, ROT_FRAC);
            rd[r] = round_half_up(acc_d, ROT_FRAC);
        end
        cr[0] = t[1] * rd[2] - t[2] * rd[1];
        cr[1] = t[2] * rd[0] - t[0] * rd[2];
        cr[2] = t[0] * rd[1] - t[1] * rd[0];
        for (int i = 0; i < 3; i++) begin
            sum   = round_half_up((rn[i] <<< TRANS_FRAC) + cr[i], TRANS_FRAC);
            nc[i] = clamp_coord(sum);
            dc[i] = clamp_coord(rd[i]);
            if (nc[i] != sum || dc[i] != rd[i]) ovf = 1'b1;
        end
        res.nx  = nc[0][COORD_W-1:0];
        res.ny  = nc[1][COORD_W-1:0];
        res.nz  = nc[2][COORD_W-1:0];
        res.dx  = dc[0][COORD_W-1:0];
        res.dy  = dc[1][COORD_W-1:0];
        res.dz  = dc[2][COORD_W-1:0];
        res.ovf = ovf;
        return res;
    endfunction

    function automatic line_t mk_line(logic [COORD_W-1:0] nx, ny, nz, dx, dy, dz);
        return '{nx, ny, nz, dx, dy, dz};
    endfunction

    function automatic cam_t mk_cam(logic [COORD_W-1:0] nx, ny, nz, dx, dy, dz,
                                    logic ovf);
        return '{nx, ny, nz, dx, dy, dz, ovf};
    endfunction

    function automatic void add_cfg(t_cfg_idx idx, logic [CFG_W-1:0] data);
        plan_row_t row;
        row        = '{is_cfg: 1'b0, idx: CFG_ROT_ROW0, data: '0, ln: '0,
                       typed: 1'b0, want: '0};
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.data   = data;
        plan.push_back(row);
    endfunction

    function automatic void add_line(line_t ln, bit typed, cam_t want);
        plan_row_t row;
        row       = '{is_cfg: 1'b0, idx: CFG_ROT_ROW0, data: '0, ln: '0,
                      typed: 1'b0, want: '0};
        row.ln    = ln;
        row.typed = typed;
        row.want  = want;
        plan.push_back(row);
    endfunction

    function automatic string fmt_cam(cam_t c);
        return $sformatf("n=(%0d,%0d,%0d) d=(%0d,%0d,%0d) ovf=%0b",
                         $signed(c.nx), $signed(c.ny), $signed(c.nz),
                         $signed(c.dx), $signed(c.dy), $signed(c.dz), c.ovf);
    endfunction

    function automatic void flag_error(string msg);
        bad_count++;
        if (bad_count <= 10) $display("ERROR: %s", msg);
    endfunction

    // mix of full-range, small and corner coordinates
    function automatic logic [COORD_W-1:0] coord_rand();
        int pick;
        int v;
        pick = $urandom_range(9);
        if (pick < 5) return COORD_W'($urandom());
        if (pick < 9) begin
            v = $urandom_range(0, 1 << 18) - (1 << 17);
            return COORD_W'(v);
        end
        case ($urandom_range(4))
            0: return C_MAX;
            1: return C_MIN;
            2: return '0;
            3: return '1;
            default: return COORD_W'(1);
        endcase
    endfunction

    function automatic line_t line_rand();
        return mk_line(coord_rand(), coord_rand(), coord_rand(),
                       coord_rand(), coord_rand(), coord_rand());
    endfunction

    // register write, only once the pipeline has drained
    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
        in_valid = 1'b0;
        while (cam_lines_due.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        case (idx)
            CFG_ROT_ROW0: rot_row[0] = data[3*ROT_W-1:0];
            CFG_ROT_ROW1: rot_row[1] = data[3*ROT_W-1:0];
            CFG_ROT_ROW2: rot_row[2] = data[3*ROT_W-1:0];
            CFG_TRANS:    trans_xyz  = data[3*TRANS_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    // one input transaction; called and returns at a falling edge
    task automatic send_line(line_t ln, bit typed, cam_t want);
        while (!calm && $urandom_range(99) < 24) begin
            in_valid = 1'b0;
            @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_line  = ln;
        do @(posedge i_clk); while (!o_in_ready);
        cam_lines_due.push_back(typed ? want : to_camera_frame(ln));
        @(negedge i_clk);
    endtask

    // output side back-pressure
    always @(negedge i_clk)
        out_ready <= calm || ($urandom_range(99) >= 24);

    // compare each result transaction with the oldest expected line
    always @(posedge i_clk) begin
        cam_t got;
        cam_t want;
        if (i_rst_n && o_out_valid && out_ready) begin
            got = {o_cam_normal_x, o_cam_normal_y, o_cam_normal_z,
                   o_cam_dir_x, o_cam_dir_y, o_cam_dir_z, o_overflow};
            if (cam_lines_due.size() == 0) begin
                flag_error($sformatf("result %0d with nothing expected: %s",
                                     result_count, fmt_cam(got)));
            end else begin
                want = cam_lines_due.pop_front();
                if (got !== want)
                    flag_error($sformatf("result %0d: want %s, got %s",
                                         result_count, fmt_cam(want), fmt_cam(got)));
            end
            result_count++;
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("** plucker_line_rigid_transform_core: FAILED **");
            $finish;
        end
    end

    initial begin
        logic [3*ROT_W-1:0]   row;
        logic [3*TRANS_W-1:0] tr;
        int                   v;
        int                   sent;

        i_rst_n   = 1'b0;
        cfg_we    = 1'b0;
        cfg_idx   = CFG_ROT_ROW0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_line   = '0;
        rot_row[0] = 48'(R_ONE);
        rot_row[1] = 48'(R_ONE) << ROT_W;
        rot_row[2] = 48'(R_ONE) << (2 * ROT_W);
        trans_xyz  = '0;
        sent       = 0;

        // identity after reset: lines pass through unchanged
        add_line('0, 1, '0);
        add_line(mk_line(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX), 1,
                 mk_cam(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 1'b0));
        add_line(mk_line(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN), 1,
                 mk_cam(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 1'b0));
        add_line(mk_line(24'h555555, 24'hAAAAAA, 24'h555555,
                         24'hAAAAAA, 24'h555555, 24'hAAAAAA), 1,
                 mk_cam(24'h555555, 24'hAAAAAA, 24'h555555,
                        24'hAAAAAA, 24'h555555, 24'hAAAAAA, 1'b0));
        add_line(mk_line(24'd1, '1, 24'd1, '1, 24'd1, '1), 1,
                 mk_cam(24'd1, '1, 24'd1, '1, 24'd1, '1, 1'b0));

        // R = -2 * I, junk above the packed fields must be ignored
        add_cfg(CFG_ROT_ROW0, {12'hABC, 48'h0000_0000_8000});
        add_cfg(CFG_ROT_ROW1, {12'h5A5, 48'h0000_8000_0000});
        add_cfg(CFG_ROT_ROW2, {12'hFFF, 48'h8000_0000_0000});
        add_line(mk_line(C_MAX, C_MIN, '0, C_MIN, C_MAX, 24'd1), 1,
                 mk_cam(C_MIN, C_MAX, '0, C_MAX, C_MIN, -24'sd2, 1'b1));
        add_line('0, 1, '0);
        add_line(mk_line(24'd1, 24'd2, 24'd3, -24'sd1, '0, 24'd5), 1,
                 mk_cam(-24'sd2, -24'sd4, -24'sd6, 24'd2, '0, -24'sd10, 1'b0));

        // identity with t = (1.0, 0, 0): n' = n + (0, -dz, dy)
        add_cfg(CFG_ROT_ROW0, 60'(R_ONE));
        add_cfg(CFG_ROT_ROW1, 60'(R_ONE) << ROT_W);
        add_cfg(CFG_ROT_ROW2, 60'(R_ONE) << (2 * ROT_W));
        add_cfg(CFG_TRANS, 60'd4096);
        add_line(mk_line(24'd10, 24'd20, 24'd30, 24'd1, 24'd2, 24'd3), 1,
                 mk_cam(24'd10, 24'd17, 24'd32, 24'd1, 24'd2, 24'd3, 1'b0));
        add_line(mk_line('0, C_MIN, C_MAX, '0, 24'd1, 24'd1), 1,
                 mk_cam('0, C_MIN, C_MAX, '0, 24'd1, 24'd1, 1'b1));

        // smallest rotation step: rounding ties on both signs
        add_cfg(CFG_ROT_ROW0, 60'd1);
        add_cfg(CFG_TRANS, '0);
        add_line(mk_line(24'd8192, '0, '0, 24'd8192, '0, '0), 0, '0);
        add_line(mk_line(-24'sd8192, '0, '0, -24'sd8192, '0, '0), 0, '0);
        add_line(mk_line(24'd24576, 24'd1, 24'd1, -24'sd24576, 24'd1, 24'd1), 0, '0);
        add_line(mk_line(-24'sd8193, '0, '0, 24'd8191, '0, '0), 0, '0);

        // every rotation entry and translation at the positive extreme
        add_cfg(CFG_ROT_ROW0, 60'h0007FFF7FFF7FFF);
        add_cfg(CFG_ROT_ROW1, 60'h0007FFF7FFF7FFF);
        add_cfg(CFG_ROT_ROW2, 60'h0007FFF7FFF7FFF);
        add_cfg(CFG_TRANS, {20'h7FFFF, 20'h7FFFF, 20'h7FFFF});
        add_line(mk_line(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN), 0, '0);
        add_line(mk_line(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX), 0, '0);

        // and at the negative extreme
        add_cfg(CFG_ROT_ROW0, 60'hFFF800080008000);
        add_cfg(CFG_ROT_ROW1, 60'hFFF800080008000);
        add_cfg(CFG_ROT_ROW2, 60'hFFF800080008000);
        add_cfg(CFG_TRANS, {20'h80000, 20'h80000, 20'h80000});
        add_line(mk_line(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN), 0, '0);
        add_line(mk_line(24'd3, 24'd100, -24'sd77, 24'd65536, -24'sd65536, 24'd1), 0, '0);

        // reset
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed plan
        foreach (plan[i]) begin
            if (plan[i].is_cfg) write_reg(plan[i].idx, plan[i].data);
            else send_line(plan[i].ln, plan[i].typed, plan[i].want);
        end

        // random phases, a fresh transform for each
        for (int p = 0; p < PHASES; p++) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    case (p % 3)
                        0: row[c*ROT_W +: ROT_W] = (r == c) ? R_ONE : '0;
                        1: begin
                            v = $urandom_range(0, 32768) - 16384;
                            row[c*ROT_W +: ROT_W] = ROT_W'(v);
                        end
                        default: row[c*ROT_W +: ROT_W] = ROT_W'($urandom());
                    endcase
                end
                write_reg(ROW_REG[r], {12'($urandom()), row});
            end
            for (int i = 0; i < 3; i++) begin
                if (p % 2 == 1) begin
                    tr[i*TRANS_W +: TRANS_W] = TRANS_W'($urandom());
                end else begin
                    v = $urandom_range(0, 1 << 15) - (1 << 14);
                    tr[i*TRANS_W +: TRANS_W] = TRANS_W'(v);
                end
            end
            write_reg(CFG_TRANS, tr);
            for (int k = 0; k < PER_PHASE; k++) begin
                // long stretch with no idling on either side
                calm = (sent >= 600 && sent < 900);
                send_line(line_rand(), 0, '0);
                sent++;
            end
        end
        calm     = 1'b0;
        in_valid = 1'b0;

        // drain, then watch for stray results
        while (cam_lines_due.size() != 0) @(posedge i_clk);
        repeat (LATENCY * 4) @(posedge i_clk);

        if (bad_count == 0 && cam_lines_due.size() == 0)
            $display("** plucker_line_rigid_transform_core: PASSED **");
        else
            $display("** plucker_line_rigid_transform_core: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
